// ----- rtl/core/hrfp_pkg.sv -----
`default_nettype none
package hrfp_pkg;

  // input item kinds
  localparam logic [1:0] MODE_NAL     = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TRANSPORT_MODE     = 3'd0;
  localparam logic [2:0] REG_SOURCE_ID          = 3'd1;
  localparam logic [2:0] REG_PAYLOAD_TYPE       = 3'd2;
  localparam logic [2:0] REG_PAY_LIMIT          = 3'd3;
  localparam logic [2:0] REG_TIMESTAMP_STEP     = 3'd4;
  localparam logic [2:0] REG_INTERLEAVE_CHANNEL = 3'd5;

  localparam int unsigned APB_ADDR_BITS = 5;

  // register reset values
  localparam logic [31:0] RESET_SOURCE_ID    = 32'h1234_5678;
  localparam logic [6:0]  RESET_PAYLOAD_TYPE = 7'd96;
  localparam logic [10:0] RESET_PAY_LIMIT    = 11'd1388;
  localparam logic [31:0] RESET_STEP         = 32'd3000;

  // payload limit clamp
  localparam logic [10:0] PAYLOAD_MIN = 11'd16;
  localparam logic [10:0] PAYLOAD_MAX = 11'd1488;

  // packet constants
  localparam logic [7:0]  RTP_VPXCC     = 8'h80;
  localparam logic [7:0]  FU_A_TYPE     = 8'd28;
  localparam logic [7:0]  FU_START_BIT  = 8'h80;
  localparam logic [7:0]  FU_END_BIT    = 8'h40;
  localparam logic [7:0]  NRI_MASK      = 8'hE0;
  localparam logic [7:0]  TYPE_MASK     = 8'h1F;
  localparam logic [7:0]  TCP_MAGIC     = 8'h24;
  localparam logic [10:0] RTP_HDR_BYTES = 11'd12;
  localparam logic [10:0] FU_HDR_BYTES  = 11'd2;

  localparam int unsigned NAL_LENGTH_BITS_DEF = 20;
  localparam int unsigned JOB_DEPTH_DEF       = 2;

  // byte positions of the output sequencer
  localparam logic [4:0] POS_PFX0  = 5'd0;
  localparam logic [4:0] POS_PFX1  = 5'd1;
  localparam logic [4:0] POS_PFX2  = 5'd2;
  localparam logic [4:0] POS_PFX3  = 5'd3;
  localparam logic [4:0] POS_RTP0  = 5'd4;
  localparam logic [4:0] POS_RTP1  = 5'd5;
  localparam logic [4:0] POS_RTP2  = 5'd6;
  localparam logic [4:0] POS_RTP3  = 5'd7;
  localparam logic [4:0] POS_RTP4  = 5'd8;
  localparam logic [4:0] POS_RTP5  = 5'd9;
  localparam logic [4:0] POS_RTP6  = 5'd10;
  localparam logic [4:0] POS_RTP7  = 5'd11;
  localparam logic [4:0] POS_RTP8  = 5'd12;
  localparam logic [4:0] POS_RTP9  = 5'd13;
  localparam logic [4:0] POS_RTP10 = 5'd14;
  localparam logic [4:0] POS_RTP11 = 5'd15;
  localparam logic [4:0] POS_FU0   = 5'd16;
  localparam logic [4:0] POS_FU1   = 5'd17;
  localparam logic [4:0] POS_DATA  = 5'd18;

  // configuration as seen by front and back
  typedef struct packed {
    logic        tcp;
    logic [31:0] ssrc;
    logic [6:0]  pt;
    logic [10:0] pay_limit;
    logic [31:0] step;
    logic [7:0]  chan;
  } hrfp_cfg_t;

  // one classified word: optional headers plus one payload byte
  typedef struct packed {
    logic        hdr;
    logic        fu;
    logic        marker;
    logic [10:0] total;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        last;
  } hrfp_job_t;

endpackage
`default_nettype wire

// ----- rtl/core/h264_rtp_fua_packetizer.sv -----
// channel   | handshake                   | words
// ----------+-----------------------------+------------------------------------
// input     | push / full                 | mode_i, data_byte_i, nalu_length_i
// output    | empty / pop                 | out_byte_o, packet_last_o
// config    | psel, penable, pwrite/pready| paddr (byte addr 4*index), pwdata
//
// A NAL payload byte gives one output byte; a packet start adds 12 header bytes
// (16 with the TCP prefix, plus 2 for FU-A), sent by the one-byte-per-cycle
// output sequencer while words are queued and pop keeps up. Timestamp and clear items give no output.
// While a header goes out the two-word queue holds its word and one more, then
// full stays high until the payload byte of the header word has been sent.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none
module h264_rtp_fua_packetizer
  import hrfp_pkg::*;
#(
  parameter int unsigned NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEF,
  parameter int unsigned JOB_DEPTH       = JOB_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // config port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input side
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic [NAL_LENGTH_BITS-1:0] nalu_length_i,
  // output side
  output logic                            empty,
  input  wire logic                       pop,
  output logic [7:0]                      out_byte_o,
  output logic                            packet_last_o
);

  hrfp_cfg_t  cfg_q;
  hrfp_job_t  fr_job, q_job;
  logic       fr_push;
  logic       q_full, q_empty;
  logic       bk_pop;
  logic       out_valid;
  logic       item_valid;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tcp       <= 1'b0;
      cfg_q.ssrc      <= RESET_SOURCE_ID;
      cfg_q.pt        <= RESET_PAYLOAD_TYPE;
      cfg_q.pay_limit <= RESET_PAY_LIMIT;
      cfg_q.step      <= RESET_STEP;
      cfg_q.chan      <= 8'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRANSPORT_MODE:     cfg_q.tcp       <= pwdata[0];
        REG_SOURCE_ID:          cfg_q.ssrc      <= pwdata;
        REG_PAYLOAD_TYPE:       cfg_q.pt        <= pwdata[6:0];
        REG_PAY_LIMIT:          cfg_q.pay_limit <= pwdata[10:0];
        REG_TIMESTAMP_STEP:     cfg_q.step      <= pwdata;
        REG_INTERLEAVE_CHANNEL: cfg_q.chan      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_TRANSPORT_MODE:     prdata = {31'd0, cfg_q.tcp};
      REG_SOURCE_ID:          prdata = cfg_q.ssrc;
      REG_PAYLOAD_TYPE:       prdata = {25'd0, cfg_q.pt};
      REG_PAY_LIMIT:          prdata = {21'd0, cfg_q.pay_limit};
      REG_TIMESTAMP_STEP:     prdata = cfg_q.step;
      REG_INTERLEAVE_CHANNEL: prdata = {24'd0, cfg_q.chan};
      default:                prdata = 32'd0;
    endcase
  end

  assign full       = q_full;
  assign item_valid = push && !q_full;

  hrfp_front #(
    .NAL_LENGTH_BITS(NAL_LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .nalu_length_i (nalu_length_i),
    .job_o         (fr_job),
    .job_push_o    (fr_push)
  );

  hrfp_queue #(
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .wdata_i (fr_job),
    .pop_i   (bk_pop),
    .rdata_o (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hrfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_empty),
    .job_i       (q_job),
    .job_pop_o   (bk_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_byte_o  (out_byte_o),
    .out_last_o  (packet_last_o)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire

// ----- rtl/core/hrfp_front.sv -----
`default_nettype none
module hrfp_front
  import hrfp_pkg::*;
#(
  parameter int unsigned NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire hrfp_cfg_t                  cfg_i,
  input  wire logic                       item_valid_i,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic [NAL_LENGTH_BITS-1:0] nalu_length_i,
  output hrfp_job_t                       job_o,
  output logic                            job_push_o
);

  logic [15:0]                seq_q, seq_d;
  logic [31:0]                ts_q, ts_d;
  logic [NAL_LENGTH_BITS-1:0] nbl_q, nbl_d;
  logic [7:0]                 hb_q, hb_d;
  logic                       frag_q, frag_d;
  logic [10:0]                fbl_q, fbl_d;
  logic                       first_q, first_d;

  logic [10:0]                mp;
  logic [10:0]                mp_frag;
  logic [10:0]                chunk;
  logic                       last_frag;
  logic [10:0]                fbl_cur;
  logic [10:0]                fbl_next;
  logic [NAL_LENGTH_BITS-1:0] nbl_next;

  // clamp the payload limit
  always_comb begin
    mp = cfg_i.pay_limit;
    if (mp < PAYLOAD_MIN) begin
      mp = PAYLOAD_MIN;
    end else if (mp > PAYLOAD_MAX) begin
      mp = PAYLOAD_MAX;
    end
    mp_frag = mp - FU_HDR_BYTES;
  end

  // fragment size for the next FU-A packet
  always_comb begin
    if (nbl_q > NAL_LENGTH_BITS'(mp_frag)) begin
      chunk = mp_frag;
    end else begin
      chunk = nbl_q[10:0];
    end
    last_frag = (NAL_LENGTH_BITS'(chunk) == nbl_q);
    fbl_cur   = (fbl_q == 11'd0) ? chunk : fbl_q;
    fbl_next  = fbl_cur - 11'd1;
    nbl_next  = nbl_q - NAL_LENGTH_BITS'(1);
  end

  // classify the item and update the packetizer state
  always_comb begin
    seq_d      = seq_q;
    ts_d       = ts_q;
    nbl_d      = nbl_q;
    hb_d       = hb_q;
    frag_d     = frag_q;
    fbl_d      = fbl_q;
    first_d    = first_q;
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.seq  = seq_q;
    job_o.ts   = ts_q;
    job_o.data = data_byte_i;
    if (item_valid_i) begin
      unique case (mode_i)
        MODE_ADVANCE: ts_d = ts_q + cfg_i.step;
        MODE_CLEAR: begin
          seq_d = 16'd0;
          ts_d  = 32'd0;
        end
        MODE_NAL: begin
          if (nbl_q == '0) begin
            if (nalu_length_i != '0) begin
              nbl_d = nalu_length_i - NAL_LENGTH_BITS'(1);
              if (nalu_length_i <= NAL_LENGTH_BITS'(mp)) begin
                frag_d       = 1'b0;
                job_push_o   = 1'b1;
                job_o.hdr    = 1'b1;
                job_o.marker = 1'b1;
                job_o.total  = RTP_HDR_BYTES + nalu_length_i[10:0];
                job_o.last   = (nalu_length_i == NAL_LENGTH_BITS'(1));
                seq_d        = seq_q + 16'd1;
              end else begin
                hb_d    = data_byte_i;
                frag_d  = 1'b1;
                first_d = 1'b1;
                fbl_d   = 11'd0;
              end
            end
          end else if (!frag_q) begin
            nbl_d      = nbl_next;
            job_push_o = 1'b1;
            job_o.last = (nbl_next == '0);
          end else begin
            job_push_o = 1'b1;
            if (fbl_q == 11'd0) begin
              job_o.hdr    = 1'b1;
              job_o.fu     = 1'b1;
              job_o.marker = last_frag;
              job_o.total  = RTP_HDR_BYTES + FU_HDR_BYTES + chunk;
              job_o.fu_ind = (hb_q & NRI_MASK) | FU_A_TYPE;
              job_o.fu_hdr = (first_q ? FU_START_BIT : 8'h00) |
                             (last_frag ? FU_END_BIT : 8'h00) | (hb_q & TYPE_MASK);
              first_d      = 1'b0;
              seq_d        = seq_q + 16'd1;
            end
            fbl_d      = fbl_next;
            nbl_d      = nbl_next;
            job_o.last = (fbl_next == 11'd0);
            if (nbl_next == '0) begin
              frag_d = 1'b0;
              fbl_d  = 11'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 16'd0;
      ts_q    <= 32'd0;
      nbl_q   <= '0;
      hb_q    <= 8'd0;
      frag_q  <= 1'b0;
      fbl_q   <= 11'd0;
      first_q <= 1'b1;
    end else begin
      seq_q   <= seq_d;
      ts_q    <= ts_d;
      nbl_q   <= nbl_d;
      hb_q    <= hb_d;
      frag_q  <= frag_d;
      fbl_q   <= fbl_d;
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/hrfp_queue.sv -----
`default_nettype none
module hrfp_queue
  import hrfp_pkg::*;
#(
  parameter int unsigned DEPTH = JOB_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire hrfp_job_t wdata_i,
  input  wire logic      pop_i,
  output hrfp_job_t      rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  hrfp_job_t           mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_BITS'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("job queue count out of range");

  a_fill_to_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && count_q == CNT_BITS'(DEPTH - 1)) |=> full_o)
    else $error("job queue did not report full");

endmodule
`default_nettype wire

// ----- rtl/core/hrfp_back.sv -----
`default_nettype none
module hrfp_back
  import hrfp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire hrfp_cfg_t cfg_i,
  input  wire logic      job_valid_i,
  input  wire hrfp_job_t job_i,
  output logic           job_pop_o,
  input  wire logic      pop_i,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  logic       busy_q, busy_d;
  logic [4:0] pos_q, pos_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       emit;
  logic [4:0] cur_pos;
  logic [7:0] cur_byte;
  logic [4:0] next_pos;

  assign emit = job_valid_i && (!out_valid_q || pop_i);

  // where the word starts: prefix, rtp header or payload
  always_comb begin
    if (busy_q) begin
      cur_pos = pos_q;
    end else if (!job_i.hdr) begin
      cur_pos = POS_DATA;
    end else if (cfg_i.tcp) begin
      cur_pos = POS_PFX0;
    end else begin
      cur_pos = POS_RTP0;
    end
  end

  // byte select per position
  always_comb begin
    unique case (cur_pos)
      POS_PFX0:  cur_byte = TCP_MAGIC;
      POS_PFX1:  cur_byte = cfg_i.chan;
      POS_PFX2:  cur_byte = {5'd0, job_i.total[10:8]};
      POS_PFX3:  cur_byte = job_i.total[7:0];
      POS_RTP0:  cur_byte = RTP_VPXCC;
      POS_RTP1:  cur_byte = {job_i.marker, cfg_i.pt};
      POS_RTP2:  cur_byte = job_i.seq[15:8];
      POS_RTP3:  cur_byte = job_i.seq[7:0];
      POS_RTP4:  cur_byte = job_i.ts[31:24];
      POS_RTP5:  cur_byte = job_i.ts[23:16];
      POS_RTP6:  cur_byte = job_i.ts[15:8];
      POS_RTP7:  cur_byte = job_i.ts[7:0];
      POS_RTP8:  cur_byte = cfg_i.ssrc[31:24];
      POS_RTP9:  cur_byte = cfg_i.ssrc[23:16];
      POS_RTP10: cur_byte = cfg_i.ssrc[15:8];
      POS_RTP11: cur_byte = cfg_i.ssrc[7:0];
      POS_FU0:   cur_byte = job_i.fu_ind;
      POS_FU1:   cur_byte = job_i.fu_hdr;
      default:   cur_byte = job_i.data;
    endcase
  end

  // step to the next header byte, skipping the fu bytes on single packets
  always_comb begin
    if (cur_pos == POS_RTP11) begin
      next_pos = job_i.fu ? POS_FU0 : POS_DATA;
    end else begin
      next_pos = cur_pos + 5'd1;
    end
  end

  always_comb begin
    busy_d    = busy_q;
    pos_d     = pos_q;
    job_pop_o = 1'b0;
    if (emit) begin
      if (cur_pos == POS_DATA) begin
        job_pop_o = 1'b1;
        busy_d    = 1'b0;
      end else begin
        busy_d = 1'b1;
        pos_d  = next_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= POS_PFX0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= (cur_pos == POS_DATA) && job_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> job_valid_i)
    else $error("header sequence running without a queued word");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= POS_DATA))
    else $error("sequencer position out of range");

  a_pop_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (out_valid_q && $past(cur_pos) == POS_DATA))
    else $error("word released before its payload byte");

endmodule
`default_nettype wire
